@@ rtl/core/bbdc_pkg.sv @@
// Package for the box delta decoder: fixed-point widths, register indexes,
// and the 2^f table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbdc_pkg;

    localparam int CoordFrac = 4;
    localparam int DeltaFrac = 12;
    localparam int CoordW    = 17;
    localparam int DeltaW    = 16;
    localparam int SizeW     = 14;

    localparam logic [2:0] REG_MEAN_DX = 3'd0;
    localparam logic [2:0] REG_MEAN_DY = 3'd1;
    localparam logic [2:0] REG_MEAN_DW = 3'd2;
    localparam logic [2:0] REG_MEAN_DH = 3'd3;
    localparam logic [2:0] REG_STD_DX  = 3'd4;
    localparam logic [2:0] REG_STD_DY  = 3'd5;
    localparam logic [2:0] REG_STD_DW  = 3'd6;
    localparam logic [2:0] REG_STD_DH  = 3'd7;

    localparam logic [31:0] Log2eQ30 = 32'd1549082005;

    // round(2^(i/16) * 2^16)
    function automatic logic [17:0] pow2_tab(input logic [4:0] i);
        logic [17:0] r;
        begin
            case (i)
                5'd0:  r = 18'd65536;
                5'd1:  r = 18'd68438;
                5'd2:  r = 18'd71468;
                5'd3:  r = 18'd74632;
                5'd4:  r = 18'd77936;
                5'd5:  r = 18'd81386;
                5'd6:  r = 18'd84990;
                5'd7:  r = 18'd88752;
                5'd8:  r = 18'd92682;
                5'd9:  r = 18'd96785;
                5'd10: r = 18'd101070;
                5'd11: r = 18'd105545;
                5'd12: r = 18'd110218;
                5'd13: r = 18'd115098;
                5'd14: r = 18'd120193;
                5'd15: r = 18'd125515;
                5'd16: r = 18'd131072;
                default: r = 18'd65536;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/bbdc_axis.sv @@
// One axis of the decoder: scaled deltas, centre shift, exp size, clip.
// Depends on bbdc_pkg. Seven register stages, one word per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bbdc_axis
    import bbdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_vld,
    input  wire logic [CoordW-1:0]    lo,
    input  wire logic [CoordW-1:0]    hi,
    input  wire logic signed [15:0]   dc_raw,
    input  wire logic signed [15:0]   ds_raw,
    input  wire logic [SizeW-1:0]     size,
    input  wire logic signed [15:0]   mean_c,
    input  wire logic signed [15:0]   mean_s,
    input  wire logic [15:0]          std_c,
    input  wire logic [15:0]          std_s,
    output logic [CoordW-1:0]         o_lo,
    output logic [CoordW-1:0]         o_hi
);

    // stage 1: delta products, width, edge sum
    logic signed [32:0] pc_reg, ps_reg;
    logic signed [18:0] w1_reg;
    logic [17:0]        sum1_reg;
    logic [SizeW-1:0]   sz1_reg;
    always_ff @(posedge clk)
    begin
        pc_reg   <= dc_raw * $signed({1'b0, std_c});
        ps_reg   <= ds_raw * $signed({1'b0, std_s});
        w1_reg   <= $signed({2'b0, hi}) - $signed({2'b0, lo}) + 19'sd16;
        sum1_reg <= {1'b0, lo} + {1'b0, hi};
        sz1_reg  <= size;
    end

    // stage 2: round, add mean, saturate
    function automatic logic signed [15:0] scale(input logic signed [32:0] p,
                                                 input logic signed [15:0] m);
        logic signed [21:0] r;
        logic signed [22:0] s;
        begin
            r = 22'((p + 33'sd2048) >>> DeltaFrac);
            s = 23'(r) + 23'(m);
            if (s > 23'sd32767)       return 16'sh7fff;
            else if (s < -23'sd32768) return 16'sh8000;
            else                      return 16'(s);
        end
    endfunction
    logic signed [15:0] dc2_reg, ds2_reg;
    logic signed [18:0] w2_reg;
    logic [17:0]        sum2_reg;
    logic [SizeW-1:0]   sz2_reg;
    always_ff @(posedge clk)
    begin
        dc2_reg  <= scale(pc_reg, mean_c);
        ds2_reg  <= scale(ps_reg, mean_s);
        w2_reg   <= w1_reg;
        sum2_reg <= sum1_reg;
        sz2_reg  <= sz1_reg;
    end

    // stage 3: centre shift product, log2e product
    logic signed [35:0] sh3_reg;
    logic signed [48:0] y3_reg;
    logic signed [18:0] w3_reg;
    logic [17:0]        sum3_reg;
    logic [SizeW-1:0]   sz3_reg;
    always_ff @(posedge clk)
    begin
        sh3_reg  <= dc2_reg * w2_reg;
        y3_reg   <= ds2_reg * $signed({1'b0, Log2eQ30});
        w3_reg   <= w2_reg;
        sum3_reg <= sum2_reg;
        sz3_reg  <= sz2_reg;
    end

    // stage 4: centre, exponent split, table interpolation
    logic signed [19:0] y4;
    logic signed [7:0]  k4;
    logic [11:0]        f4;
    logic [17:0]        t0, t1;
    logic [26:0]        ip;
    always_comb
    begin
        y4 = 20'((y3_reg + 49'sd536870912) >>> 30);
        k4 = 8'(y4 >>> DeltaFrac);
        f4 = y4[11:0];
        t0 = pow2_tab({1'b0, f4[11:8]});
        t1 = pow2_tab({1'b0, f4[11:8]} + 5'd1);
        ip = 27'(t1 - t0) * {19'd0, f4[7:0]};
    end
    // centre reaches about 2^21 at full shift, so it needs 23 signed bits
    logic signed [22:0] ctr4_reg;
    logic [17:0]        val4_reg;
    logic signed [7:0]  k4_reg;
    logic signed [18:0] w4_reg;
    logic [SizeW-1:0]   sz4_reg;
    always_ff @(posedge clk)
    begin
        ctr4_reg <= $signed({5'b0, sum3_reg}) + 23'((sh3_reg + 36'sd1024) >>> 11);
        val4_reg <= t0 + 18'(ip >> 8);
        k4_reg   <= k4;
        w4_reg   <= w3_reg;
        sz4_reg  <= sz3_reg;
    end

    // stage 5: shift by k
    logic [41:0] e5;
    always_comb
    begin
        if (k4_reg < -8'sd24)     e5 = '0;
        else if (k4_reg >= 8'sd24) e5 = {6'd0, val4_reg} << 24;
        else if (k4_reg >= 8'sd0)  e5 = {24'd0, val4_reg} << k4_reg[4:0];
        else                       e5 = {24'd0, val4_reg} >> 5'(-k4_reg);
    end
    logic [41:0]        e5_reg;
    logic signed [22:0] ctr5_reg;
    logic signed [18:0] w5_reg;
    logic [SizeW-1:0]   sz5_reg;
    always_ff @(posedge clk)
    begin
        e5_reg   <= e5;
        ctr5_reg <= ctr4_reg;
        w5_reg   <= w4_reg;
        sz5_reg  <= sz4_reg;
    end

    // stage 6: size product split in two halves
    logic signed [40:0] plo6_reg;
    logic signed [44:0] phi6_reg;
    logic signed [22:0] ctr6_reg;
    logic [SizeW-1:0]   sz6_reg;
    always_ff @(posedge clk)
    begin
        plo6_reg <= $signed({1'b0, e5_reg[20:0]}) * w5_reg;
        phi6_reg <= $signed({1'b0, e5_reg[41:21]}) * w5_reg;
        ctr6_reg <= ctr5_reg;
        sz6_reg  <= sz5_reg;
    end

    // stage 7: size, corners, clip
    logic signed [67:0] prod;
    logic signed [52:0] szv, half, ea, eb;
    logic signed [50:0] a, b;
    logic signed [18:0] lim;
    function automatic logic [CoordW-1:0] clip(input logic signed [50:0] v,
                                               input logic signed [18:0] l);
        logic signed [50:0] t;
        begin
            t = (v > 51'(l)) ? 51'(l) : v;
            return (t < 0) ? '0 : CoordW'(t);
        end
    endfunction
    always_comb
    begin
        prod = (68'(phi6_reg) <<< 21) + 68'(plo6_reg);
        szv  = 53'((prod + 68'sd16384) >>> 15);
        half = szv - 53'sd32;
        ea   = 53'(ctr6_reg) * 2 - half;
        eb   = 53'(ctr6_reg) * 2 + half;
        a    = 51'((ea + 53'sd2) >>> 2);
        b    = 51'((eb + 53'sd2) >>> 2);
        lim  = ($signed({5'd0, sz6_reg}) - 19'sd1) <<< CoordFrac;
        if (lim > 19'sd131071) lim = 19'sd131071;
    end
    always_ff @(posedge clk)
    begin
        o_lo <= clip(a, lim);
        o_hi <= clip(b, lim);
    end

    logic unused;
    assign unused = in_vld & rst_n;

endmodule
`default_nettype wire

@@ rtl/core/bbox_delta_decode_clip.sv @@
// Top level of the box delta decoder: config registers, valid pipe, two axes.
// Depends on bbdc_pkg and bbdc_axis.
// Throughput: one box per cycle.
// busy is never asserted; the seven stage valid pipe carries each word.
// Reset clears the valid pipe and loads register defaults (std 0.1/0.2).
// The receiver cannot stall: done pulses one cycle per result.
`timescale 1ns / 1ps
`default_nettype none
module bbox_delta_decode_clip
    import bbdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [16:0]        box_x1,
    input  wire logic [16:0]        box_y1,
    input  wire logic [16:0]        box_x2,
    input  wire logic [16:0]        box_y2,
    input  wire logic signed [15:0] delta_dx,
    input  wire logic signed [15:0] delta_dy,
    input  wire logic signed [15:0] delta_dw,
    input  wire logic signed [15:0] delta_dh,
    input  wire logic [13:0]        image_height,
    input  wire logic [13:0]        image_width,
    input  wire logic               last_box,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    done,
    output logic [16:0]             out_x1,
    output logic [16:0]             out_y1,
    output logic [16:0]             out_x2,
    output logic [16:0]             out_y2,
    output logic                    end_of_set
);

    localparam int Depth = 7;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    logic [15:0] mdx_reg, mdy_reg, mdw_reg, mdh_reg;
    logic [15:0] sdx_reg, sdy_reg, sdw_reg, sdh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mdx_reg <= '0; mdy_reg <= '0; mdw_reg <= '0; mdh_reg <= '0;
            sdx_reg <= 16'd410; sdy_reg <= 16'd410;
            sdw_reg <= 16'd819; sdh_reg <= 16'd819;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MEAN_DX: mdx_reg <= cfg_data;
                REG_MEAN_DY: mdy_reg <= cfg_data;
                REG_MEAN_DW: mdw_reg <= cfg_data;
                REG_MEAN_DH: mdh_reg <= cfg_data;
                REG_STD_DX:  sdx_reg <= cfg_data;
                REG_STD_DY:  sdy_reg <= cfg_data;
                REG_STD_DW:  sdw_reg <= cfg_data;
                REG_STD_DH:  sdh_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // valid and end-of-set pipe
    logic [Depth-1:0] vld_reg, eos_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[Depth-2:0], start};
    end
    always_ff @(posedge clk)
        eos_reg <= {eos_reg[Depth-2:0], last_box};

    assign done       = vld_reg[Depth-1];
    assign end_of_set = eos_reg[Depth-1];

    bbdc_axis u_x (
        .clk(clk), .rst_n(rst_n), .in_vld(start),
        .lo(box_x1), .hi(box_x2), .dc_raw(delta_dx), .ds_raw(delta_dw),
        .size(image_width), .mean_c(mdx_reg), .mean_s(mdw_reg),
        .std_c(sdx_reg), .std_s(sdw_reg), .o_lo(out_x1), .o_hi(out_x2)
    );

    bbdc_axis u_y (
        .clk(clk), .rst_n(rst_n), .in_vld(start),
        .lo(box_y1), .hi(box_y2), .dc_raw(delta_dy), .ds_raw(delta_dh),
        .size(image_height), .mean_c(mdy_reg), .mean_s(mdh_reg),
        .std_c(sdy_reg), .std_s(sdh_reg), .o_lo(out_y1), .o_hi(out_y2)
    );

    // each start yields a done at the end of the valid pipe, and no done appears without a start
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##7 done) else $error("result missing");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 7)) else $error("phantom result");
    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for bbox_delta_decode_clip: directed and random boxes,
// with its own fixed-point predictor. Depends on bbdc_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
    import bbdc_pkg::*;

    typedef struct {
        logic [16:0]        x1, y1, x2, y2;
        logic signed [15:0] dx, dy, dw, dh;
        logic [13:0]        ih, iw;
        logic               last;
    } box_word_t;

    typedef struct {
        logic [16:0] x1, y1, x2, y2;
        logic        eos;
    } clip_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [16:0] box_x1 = '0, box_y1 = '0, box_x2 = '0, box_y2 = '0;
    logic signed [15:0] delta_dx = '0, delta_dy = '0, delta_dw = '0, delta_dh = '0;
    logic [13:0] image_height = '0, image_width = '0;
    logic last_box = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic done;
    logic [16:0] out_x1, out_y1, out_x2, out_y2;
    logic end_of_set;

    bbox_delta_decode_clip dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .box_x1(box_x1), .box_y1(box_y1), .box_x2(box_x2), .box_y2(box_y2),
        .delta_dx(delta_dx), .delta_dy(delta_dy), .delta_dw(delta_dw),
        .delta_dh(delta_dh), .image_height(image_height), .image_width(image_width),
        .last_box(last_box), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
        .out_x1(out_x1), .out_y1(out_y1), .out_x2(out_x2), .out_y2(out_y2),
        .end_of_set(end_of_set)
    );

    always #5 clk = ~clk;

    // predictor copy of the config registers
    longint mean_q[4];
    longint std_q[4];
    longint exp_tab[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                            92682, 96785, 101070, 105545, 110218, 115098, 120193,
                            125515, 131072};

    clip_word_t pending_boxes[$];
    int errors = 0;
    int boxes_sent = 0;
    int boxes_checked = 0;
    int gap_pct = 0;
    longint cycles = 0;

    // half-up rounding shift on signed values
    function automatic longint rnd_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint scaled_delta(logic signed [15:0] d, int n);
        longint p;
        p = rnd_shr(longint'(d) * std_q[n], DeltaFrac) + mean_q[n];
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p;
    endfunction

    // exp(d) at 16 fraction bits via 2^(d*log2e)
    function automatic longint exp_q16(longint d);
        longint y, k, f, i, rem, val;
        y = rnd_shr(d * 64'sd1549082005, 30);
        k = y >>> DeltaFrac;
        f = y - (k << DeltaFrac);
        i = f >>> (DeltaFrac - 4);
        rem = f & ((longint'(1) << (DeltaFrac - 4)) - 1);
        val = exp_tab[i] + (((exp_tab[i + 1] - exp_tab[i]) * rem) >>> (DeltaFrac - 4));
        if (k > 24) k = 24;
        if (k < -24) return 0;
        if (k >= 0) return val << k;
        return val >>> (-k);
    endfunction

    function automatic logic [16:0] clip_edge(longint v, logic [13:0] size);
        longint lim;
        lim = (longint'(size) - 1) << CoordFrac;
        if (lim > 131071) lim = 131071;
        if (v > lim) v = lim;
        if (v < 0) v = 0;
        return v[16:0];
    endfunction

    function automatic void decode_edges(input logic [16:0] lo, input logic [16:0] hi,
                                input longint dc, input longint ds, input logic [13:0] size,
                                output logic [16:0] o_lo, output logic [16:0] o_hi);
        longint w, ctr, sz, half;
        w = longint'(hi) - longint'(lo) + (1 << CoordFrac);
        ctr = longint'(lo) + longint'(hi) + rnd_shr(dc * w, DeltaFrac - 1);
        sz = rnd_shr(exp_q16(ds) * w, 15);
        half = sz - 2 * (1 << CoordFrac);
        o_lo = clip_edge(rnd_shr(2 * ctr - half, 2), size);
        o_hi = clip_edge(rnd_shr(2 * ctr + half, 2), size);
    endfunction

    function automatic clip_word_t decode_box(box_word_t b);
        clip_word_t r;
        decode_edges(b.x1, b.x2, scaled_delta(b.dx, 0), scaled_delta(b.dw, 2), b.iw,
                     r.x1, r.x2);
        decode_edges(b.y1, b.y2, scaled_delta(b.dy, 1), scaled_delta(b.dh, 3), b.ih,
                     r.y1, r.y2);
        r.eos = b.last;
        return r;
    endfunction

    // one config register write, mirrored in the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx < REG_STD_DX)
            mean_q[idx] = longint'(signed'(val));
        else
            std_q[idx - REG_STD_DX] = longint'(val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [15:0] m_dx, input logic [15:0] m_dy,
                             input logic [15:0] m_dw, input logic [15:0] m_dh,
                             input logic [15:0] s_dx, input logic [15:0] s_dy,
                             input logic [15:0] s_dw, input logic [15:0] s_dh);
        write_reg(REG_MEAN_DX, m_dx);
        write_reg(REG_MEAN_DY, m_dy);
        write_reg(REG_MEAN_DW, m_dw);
        write_reg(REG_MEAN_DH, m_dh);
        write_reg(REG_STD_DX, s_dx);
        write_reg(REG_STD_DY, s_dy);
        write_reg(REG_STD_DW, s_dw);
        write_reg(REG_STD_DH, s_dh);
    endtask

    // send one word; start stays high into the next word unless a gap is drawn
    task automatic send_box(input box_word_t b);
        int idle;
        @(negedge clk);
        if ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            idle = $urandom_range(4, 1);
            repeat (idle - 1) @(negedge clk);
            @(negedge clk);
        end
        start = 1'b1;
        box_x1 = b.x1; box_y1 = b.y1; box_x2 = b.x2; box_y2 = b.y2;
        delta_dx = b.dx; delta_dy = b.dy; delta_dw = b.dw; delta_dh = b.dh;
        image_height = b.ih; image_width = b.iw;
        last_box = b.last;
        do @(posedge clk); while (busy);
        pending_boxes.push_back(decode_box(b));
        boxes_sent++;
    endtask

    // drop start, wait for every result plus pipeline latency
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (pending_boxes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic box_word_t mk_box(int x1, int y1, int x2, int y2,
                                         int dx, int dy, int dw, int dh,
                                         int ih, int iw, bit last);
        box_word_t b;
        b.x1 = x1; b.y1 = y1; b.x2 = x2; b.y2 = y2;
        b.dx = dx; b.dy = dy; b.dw = dw; b.dh = dh;
        b.ih = ih; b.iw = iw; b.last = last;
        return b;
    endfunction

    // mostly sane boxes, half of them with small deltas; some fully random words
    function automatic box_word_t rand_box;
        box_word_t b;
        int sz;
        b.x1 = $urandom; b.y1 = $urandom; b.x2 = $urandom; b.y2 = $urandom;
        b.dx = $urandom; b.dy = $urandom; b.dw = $urandom; b.dh = $urandom;
        b.ih = $urandom; b.iw = $urandom; b.last = $urandom;
        if ($urandom_range(99) < 75) begin
            sz = $urandom_range(8192, 1);
            b.iw = sz;
            b.ih = $urandom_range(8192, 1);
            b.x1 = $urandom_range(sz * 16 - 1);
            b.x2 = b.x1 + $urandom_range(4000);
            b.y1 = $urandom_range(b.ih * 16 - 1);
            b.y2 = b.y1 + $urandom_range(4000);
            if ($urandom_range(1)) begin
                b.dx = $signed(16'($urandom_range(8191))) - 4096;
                b.dy = $signed(16'($urandom_range(8191))) - 4096;
                b.dw = $signed(16'($urandom_range(16383))) - 8192;
                b.dh = $signed(16'($urandom_range(16383))) - 8192;
            end
        end
        return b;
    endfunction

    // compare each result with the oldest expectation
    always @(posedge clk) begin
        clip_word_t want;
        if (rst_n && done) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t: unexpected word x1=%0d y1=%0d x2=%0d y2=%0d eos=%0b",
                         $time, out_x1, out_y1, out_x2, out_y2, end_of_set);
                errors++;
            end else begin
                want = pending_boxes.pop_front();
                boxes_checked++;
                if (out_x1 !== want.x1 || out_y1 !== want.y1 || out_x2 !== want.x2 ||
                    out_y2 !== want.y2 || end_of_set !== want.eos) begin
                    $display("%0t: mismatch expected %0d %0d %0d %0d eos=%0b", $time,
                             want.x1, want.y1, want.x2, want.y2, want.eos);
                    $display("%0t:          actual   %0d %0d %0d %0d eos=%0b", $time,
                             out_x1, out_y1, out_x2, out_y2, end_of_set);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // defaults, degenerate and inverted boxes, exp saturation, clip corners, extreme configs
    task automatic test_directed;
        send_box(mk_box(160, 160, 800, 800, 0, 0, 0, 0, 100, 100, 0));
        send_box(mk_box(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        send_box(mk_box(131071, 131071, 131071, 131071, 32767, 32767, 32767, 32767,
                        16383, 16383, 0));
        send_box(mk_box(131071, 131071, 0, 0, -32768, -32768, -32768, -32768,
                        8192, 8192, 1));
        send_box(mk_box(800, 800, 784, 784, 4096, -4096, 0, 0, 64, 64, 0));
        send_box(mk_box(100, 100, 84, 84, 0, 0, 4096, 4096, 64, 64, 0));
        send_box(mk_box(1000, 2000, 3000, 4000, 1000, -1000, 2000, -2000, 0, 0, 1));
        send_box(mk_box(1000, 2000, 3000, 4000, 1000, -1000, 2000, -2000, 8192, 8192, 0));
        send_box(mk_box(0, 0, 131071, 131071, 0, 0, 0, 0, 16383, 1, 1));
        send_box(mk_box(50000, 60000, 51000, 61000, 200, -300, -9000, 9000, 4000, 5000, 0));
        drain();
        // huge exponent both ways, maximum scale, extreme means
        write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(mk_box(160, 160, 800, 800, 32767, -32768, 32767, -32768, 8192, 8192, 1));
        send_box(mk_box(160, 160, 800, 800, -32768, 32767, -32768, 32767, 8192, 8192, 0));
        send_box(mk_box(16, 16, 32, 32, 100, 100, 100, 100, 2, 2, 1));
        drain();
        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_box(mk_box(160, 160, 800, 800, 32767, -32768, 32767, -32768, 100, 100, 0));
        send_box(mk_box(131071, 0, 0, 131071, 0, 0, 0, 0, 8192, 8192, 1));
        drain();
        write_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h1000, 16'h1000, 16'h1000, 16'h1000);
        send_box(mk_box(1600, 1600, 3200, 3200, 0, 0, 0, 0, 8192, 8192, 0));
        send_box(mk_box(1600, 1600, 3200, 3200, 4096, 4096, -4096, 4096, 500, 500, 1));
        drain();
    endtask

    task automatic test_random(input int n, input int pct);
        gap_pct = pct;
        repeat (n) send_box(rand_box());
        drain();
    endtask

    task automatic test_random_config;
        write_all($urandom, $urandom, $urandom, $urandom,
                  $urandom_range(8191), $urandom_range(8191),
                  $urandom_range(8191), $urandom_range(8191));
    endtask

    initial begin
        mean_q = '{0, 0, 0, 0};
        std_q = '{410, 410, 819, 819};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'd410, 16'd410, 16'd819, 16'd819);
        test_random(250, 11);
        test_random_config();
        test_random(150, 67);
        test_random_config();
        test_random(150, 67);
        write_all(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                  16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        test_random(50, 11);
        test_random_config();
        test_random(250, 0);

        $display("Covered %0d boxes, %0d results checked, over default, extreme and",
                 boxes_sent, boxes_checked);
        $display("random scale/offset settings with sparse, heavy and no input gaps.");
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bbdc_pkg.sv
rtl/core/bbdc_axis.sv
rtl/core/bbox_delta_decode_clip.sv
test/testbench.sv
